FILE: sv/ecdsa_pkg.sv
// Shared types, constants and the sequencer microprogram for the small-curve signer.
// Used by ecdsa_ctrl, ecdsa_dp and the top level; no dependencies.
package ecdsa_pkg;

  localparam int unsigned WidthDefault = 16;
  localparam int unsigned CfgIdxW      = 3;
  localparam int unsigned StatusW      = 3;
  localparam int unsigned PcW          = 7;
  localparam int unsigned NumRf        = 17;

  localparam int unsigned FieldPrimeRst = 11;
  localparam int unsigned CoeffARst     = 1;
  localparam int unsigned GroupOrderRst = 13;
  localparam int unsigned BaseXRst      = 2;
  localparam int unsigned BaseYRst      = 7;
  localparam int unsigned PrivKeyRst    = 1;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_FIELD_PRIME   = 3'd0,
    CFG_CURVE_COEFF_A = 3'd1,
    CFG_GROUP_ORDER   = 3'd2,
    CFG_BASE_X        = 3'd3,
    CFG_BASE_Y        = 3'd4,
    CFG_PRIVATE_KEY   = 3'd5
  } cfg_idx_e;

  typedef enum logic [StatusW-1:0] {
    STS_OK        = 3'd0,
    STS_BAD_NONCE = 3'd1,
    STS_R_ZERO    = 3'd2,
    STS_S_ZERO    = 3'd3,
    STS_INFINITY  = 3'd4
  } status_e;

  typedef enum logic [4:0] {
    OP_MOV, OP_ADD, OP_SUB, OP_CSUB, OP_MUL, OP_DIV, OP_ISET, OP_IDEC,
    OP_J, OP_JEQ, OP_JNE, OP_JLT, OP_JKB0, OP_JKB1, OP_JMB0, OP_JIZ,
    OP_CALL, OP_RET, OP_FIN
  } op_e;

  // register file entries first, then named registers, then constants/config
  typedef enum logic [4:0] {
    R_X = 5'd0, R_Y, R_AX, R_AY, R_A, R_KINV, R_T0, R_T1, R_R0, R_R1,
    R_U, R_V, R_W, R_LAM, R_H, R_R, R_S,
    R_M, R_QT, R_K, R_MSG,
    C_ZERO, C_ONE, C_TWO, C_THREE, C_P, C_Q, C_CA, C_BX, C_BY, C_PRIV
  } sel_e;

  typedef struct packed {
    op_e            op;
    sel_e           dst;
    sel_e           sa;
    sel_e           sb;
    logic [PcW-1:0] tgt;
    status_e        code;
  } instr_t;

  typedef struct packed {
    logic    load;
    logic    fetch;
    logic    exec;
    op_e     op;
    sel_e    dst;
    sel_e    sa;
    sel_e    sb;
    status_e code;
  } dp_cmd_t;

  typedef struct packed {
    logic eq;
    logic lt;
    logic kbit;
    logic mbit;
    logic izero;
    logic done;
  } dp_sts_t;

  localparam int unsigned LBadK  = 43;
  localparam int unsigned LInf   = 44;
  localparam int unsigned LRZero = 45;
  localparam int unsigned LSZero = 46;
  localparam int unsigned LInv   = 47;
  localparam int unsigned LDbl   = 62;
  localparam int unsigned LAddP  = 78;

  function automatic instr_t alu(op_e op, sel_e d, sel_e a, sel_e b);
    instr_t i;
    i = '{op: op, dst: d, sa: a, sb: b, tgt: '0, code: STS_OK};
    return i;
  endfunction

  function automatic instr_t br(op_e op, sel_e a, sel_e b, int unsigned t);
    instr_t i;
    i = '{op: op, dst: C_ZERO, sa: a, sb: b, tgt: PcW'(t), code: STS_OK};
    return i;
  endfunction

  function automatic instr_t fin(status_e c);
    instr_t i;
    i = '{op: OP_FIN, dst: C_ZERO, sa: R_R, sb: R_S, tgt: '0, code: c};
    return i;
  endfunction

  // Microprogram: nonce check and k^-1, scalar multiply, r, 2^msg, s.
  // INV: T0 = U^-1 mod M, R0 = gcd. DBL / ADDP: (X,Y) point ops mod M = p.
  function automatic instr_t prog(logic [PcW-1:0] pc);
    instr_t i;
    unique case (pc)
      7'd0:  i = alu(OP_MOV, R_M, C_Q, C_ZERO);
      7'd1:  i = br(OP_JLT, C_Q, C_TWO, LBadK);
      7'd2:  i = br(OP_JEQ, R_K, C_ZERO, LBadK);
      7'd3:  i = br(OP_JLT, R_K, C_Q, 5);
      7'd4:  i = br(OP_J, C_ZERO, C_ZERO, LBadK);
      7'd5:  i = alu(OP_MOV, R_U, R_K, C_ZERO);
      7'd6:  i = br(OP_CALL, C_ZERO, C_ZERO, LInv);
      7'd7:  i = br(OP_JNE, R_R0, C_ONE, LBadK);
      7'd8:  i = alu(OP_MOV, R_KINV, R_T0, C_ZERO);
      7'd9:  i = br(OP_JLT, C_P, C_THREE, LInf);
      7'd10: i = alu(OP_MOV, R_M, C_P, C_ZERO);
      7'd11: i = alu(OP_DIV, R_A, C_CA, R_M);
      7'd12: i = alu(OP_DIV, R_AX, C_BX, R_M);
      7'd13: i = alu(OP_DIV, R_AY, C_BY, R_M);
      7'd14: i = alu(OP_MOV, R_X, R_AX, C_ZERO);
      7'd15: i = alu(OP_MOV, R_Y, R_AY, C_ZERO);
      7'd16: i = alu(OP_ISET, C_ZERO, C_ZERO, C_ZERO);
      7'd17: i = br(OP_JKB1, C_ZERO, C_ZERO, 20);
      7'd18: i = alu(OP_IDEC, C_ZERO, C_ZERO, C_ZERO);
      7'd19: i = br(OP_J, C_ZERO, C_ZERO, 17);
      7'd20: i = br(OP_JIZ, C_ZERO, C_ZERO, 26);
      7'd21: i = alu(OP_IDEC, C_ZERO, C_ZERO, C_ZERO);
      7'd22: i = br(OP_CALL, C_ZERO, C_ZERO, LDbl);
      7'd23: i = br(OP_JKB0, C_ZERO, C_ZERO, 20);
      7'd24: i = br(OP_CALL, C_ZERO, C_ZERO, LAddP);
      7'd25: i = br(OP_J, C_ZERO, C_ZERO, 20);
      7'd26: i = alu(OP_MOV, R_M, C_Q, C_ZERO);
      7'd27: i = alu(OP_DIV, R_R, R_X, R_M);
      7'd28: i = br(OP_JEQ, R_R, C_ZERO, LRZero);
      7'd29: i = alu(OP_MOV, R_H, C_ONE, C_ZERO);
      7'd30: i = alu(OP_ISET, C_ZERO, C_ZERO, C_ZERO);
      7'd31: i = alu(OP_MUL, R_H, R_H, R_H);
      7'd32: i = br(OP_JMB0, C_ZERO, C_ZERO, 34);
      7'd33: i = alu(OP_ADD, R_H, R_H, R_H);
      7'd34: i = br(OP_JIZ, C_ZERO, C_ZERO, 37);
      7'd35: i = alu(OP_IDEC, C_ZERO, C_ZERO, C_ZERO);
      7'd36: i = br(OP_J, C_ZERO, C_ZERO, 31);
      7'd37: i = alu(OP_DIV, R_U, C_PRIV, R_M);
      7'd38: i = alu(OP_MUL, R_U, R_U, R_R);
      7'd39: i = alu(OP_ADD, R_U, R_H, R_U);
      7'd40: i = alu(OP_MUL, R_S, R_KINV, R_U);
      7'd41: i = br(OP_JEQ, R_S, C_ZERO, LSZero);
      7'd42: i = fin(STS_OK);
      7'd43: i = fin(STS_BAD_NONCE);
      7'd44: i = fin(STS_INFINITY);
      7'd45: i = fin(STS_R_ZERO);
      7'd46: i = fin(STS_S_ZERO);
      // INV
      7'd47: i = alu(OP_MOV, R_R0, R_M, C_ZERO);
      7'd48: i = alu(OP_MOV, R_R1, R_U, C_ZERO);
      7'd49: i = alu(OP_MOV, R_T0, C_ZERO, C_ZERO);
      7'd50: i = alu(OP_MOV, R_T1, C_ONE, C_ZERO);
      7'd51: i = br(OP_JEQ, R_R1, C_ZERO, 61);
      7'd52: i = alu(OP_DIV, R_W, R_R0, R_R1);
      7'd53: i = alu(OP_MOV, R_R0, R_R1, C_ZERO);
      7'd54: i = alu(OP_MOV, R_R1, R_W, C_ZERO);
      7'd55: i = alu(OP_CSUB, R_QT, R_QT, R_M);
      7'd56: i = alu(OP_MUL, R_W, R_QT, R_T1);
      7'd57: i = alu(OP_SUB, R_W, R_T0, R_W);
      7'd58: i = alu(OP_MOV, R_T0, R_T1, C_ZERO);
      7'd59: i = alu(OP_MOV, R_T1, R_W, C_ZERO);
      7'd60: i = br(OP_J, C_ZERO, C_ZERO, 51);
      7'd61: i = br(OP_RET, C_ZERO, C_ZERO, 0);
      // DBL
      7'd62: i = alu(OP_ADD, R_U, R_Y, R_Y);
      7'd63: i = br(OP_CALL, C_ZERO, C_ZERO, LInv);
      7'd64: i = br(OP_JNE, R_R0, C_ONE, LInf);
      7'd65: i = alu(OP_MUL, R_V, R_X, R_X);
      7'd66: i = alu(OP_ADD, R_W, R_V, R_V);
      7'd67: i = alu(OP_ADD, R_W, R_W, R_V);
      7'd68: i = alu(OP_ADD, R_W, R_W, R_A);
      7'd69: i = alu(OP_MUL, R_LAM, R_W, R_T0);
      7'd70: i = alu(OP_MUL, R_V, R_LAM, R_LAM);
      7'd71: i = alu(OP_ADD, R_W, R_X, R_X);
      7'd72: i = alu(OP_SUB, R_V, R_V, R_W);
      7'd73: i = alu(OP_SUB, R_W, R_X, R_V);
      7'd74: i = alu(OP_MUL, R_W, R_LAM, R_W);
      7'd75: i = alu(OP_SUB, R_Y, R_W, R_Y);
      7'd76: i = alu(OP_MOV, R_X, R_V, C_ZERO);
      7'd77: i = br(OP_RET, C_ZERO, C_ZERO, 0);
      // ADDP; equal points fall into DBL, whose return serves the caller
      7'd78: i = br(OP_JNE, R_X, R_AX, 80);
      7'd79: i = br(OP_JEQ, R_Y, R_AY, LDbl);
      7'd80: i = alu(OP_SUB, R_U, R_AX, R_X);
      7'd81: i = br(OP_CALL, C_ZERO, C_ZERO, LInv);
      7'd82: i = br(OP_JNE, R_R0, C_ONE, LInf);
      7'd83: i = alu(OP_SUB, R_W, R_AY, R_Y);
      7'd84: i = alu(OP_MUL, R_LAM, R_W, R_T0);
      7'd85: i = alu(OP_MUL, R_V, R_LAM, R_LAM);
      7'd86: i = alu(OP_SUB, R_V, R_V, R_X);
      7'd87: i = alu(OP_SUB, R_V, R_V, R_AX);
      7'd88: i = alu(OP_SUB, R_W, R_X, R_V);
      7'd89: i = alu(OP_MUL, R_W, R_LAM, R_W);
      7'd90: i = alu(OP_SUB, R_Y, R_W, R_Y);
      7'd91: i = alu(OP_MOV, R_X, R_V, C_ZERO);
      7'd92: i = br(OP_RET, C_ZERO, C_ZERO, 0);
      default: i = fin(STS_INFINITY);
    endcase
    return i;
  endfunction

endpackage

FILE: sv/ecdsa_ctrl.sv
// Sequencer: program counter, two-deep return stack and the fetch/exec/wait FSM.
// Depends on ecdsa_pkg; drives ecdsa_dp through dp_cmd_t / dp_sts_t.
module ecdsa_ctrl import ecdsa_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    start_i,
  output logic    busy_o,
  output dp_cmd_t cmd_o,
  input  dp_sts_t sts_i
);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_FETCH = 4'b0010,
    S_EXEC  = 4'b0100,
    S_WAIT  = 4'b1000
  } state_e;

  state_e         state_q, state_d;
  logic [PcW-1:0] pc_q, pc_d, stk0_q, stk0_d, stk1_q, stk1_d;
  logic [PcW-1:0] pc_inc;
  instr_t         instr;

  assign instr  = prog(pc_q);
  assign pc_inc = pc_q + 1'b1;
  assign busy_o = (state_q != S_IDLE);

  always_comb begin
    state_d = state_q;
    pc_d    = pc_q;
    stk0_d  = stk0_q;
    stk1_d  = stk1_q;
    cmd_o   = '{load: 1'b0, fetch: 1'b0, exec: 1'b0, op: instr.op, dst: instr.dst,
                sa: instr.sa, sb: instr.sb, code: instr.code};
    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          cmd_o.load = 1'b1;
          pc_d       = '0;
          state_d    = S_FETCH;
        end
      end
      S_FETCH: begin
        cmd_o.fetch = 1'b1;
        state_d     = S_EXEC;
      end
      S_EXEC: begin
        cmd_o.exec = 1'b1;
        pc_d       = pc_inc;
        state_d    = S_FETCH;
        unique case (instr.op)
          OP_MUL, OP_DIV: begin
            pc_d    = pc_q;
            state_d = S_WAIT;
          end
          OP_J:    pc_d = instr.tgt;
          OP_JEQ:  if (sts_i.eq) pc_d = instr.tgt;
          OP_JNE:  if (!sts_i.eq) pc_d = instr.tgt;
          OP_JLT:  if (sts_i.lt) pc_d = instr.tgt;
          OP_JKB0: if (!sts_i.kbit) pc_d = instr.tgt;
          OP_JKB1: if (sts_i.kbit) pc_d = instr.tgt;
          OP_JMB0: if (!sts_i.mbit) pc_d = instr.tgt;
          OP_JIZ:  if (sts_i.izero) pc_d = instr.tgt;
          OP_CALL: begin
            stk1_d = stk0_q;
            stk0_d = pc_inc;
            pc_d   = instr.tgt;
          end
          OP_RET: begin
            pc_d   = stk0_q;
            stk0_d = stk1_q;
          end
          OP_FIN:  state_d = S_IDLE;
          default: ;
        endcase
      end
      S_WAIT: begin
        if (sts_i.done) begin
          pc_d    = pc_inc;
          state_d = S_FETCH;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      pc_q    <= '0;
      stk0_q  <= '0;
      stk1_q  <= '0;
    end else begin
      state_q <= state_d;
      pc_q    <= pc_d;
      stk0_q  <= stk0_d;
      stk1_q  <= stk1_d;
    end
  end

`ifndef ASSERT_OFF
  a_wait_on_unit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_WAIT |-> (instr.op == OP_MUL || instr.op == OP_DIV))
    else $error("waiting on a non multi-cycle op");
  a_start_fetch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE && start_i) |=> (state_q == S_FETCH && pc_q == '0))
    else $error("start did not restart the program");
  a_fin_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EXEC && instr.op == OP_FIN) |=> state_q == S_IDLE)
    else $error("finish did not return to idle");
`endif

endmodule

FILE: sv/ecdsa_dp.sv
// Datapath: config registers, operand register file, modular add/sub, shared
// bit-serial modular multiply / restoring divide unit, result registers. Uses ecdsa_pkg.
module ecdsa_dp import ecdsa_pkg::*; #(
  parameter int unsigned WIDTH = WidthDefault
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  dp_cmd_t            cmd_i,
  output dp_sts_t            sts_o,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [WIDTH-1:0]   cfg_data_i,
  input  logic [WIDTH-1:0]   message_i,
  input  logic [WIDTH-1:0]   nonce_i,
  output logic               done_o,
  output logic [WIDTH-1:0]   sig_r_o,
  output logic [WIDTH-1:0]   sig_s_o,
  output logic [StatusW-1:0] status_o
);

  localparam int unsigned IdxW   = $clog2(WIDTH);
  localparam int unsigned RfIdxW = $clog2(NumRf);

  logic [WIDTH-1:0] p_q, ca_q, q_q, bx_q, by_q, priv_q;
  logic [WIDTH-1:0] rf_q [NumRf];
  logic [WIDTH-1:0] m_q, qt_q, k_q, msg_q, opa_q, opb_q;
  logic [WIDTH-1:0] ma_q, mb_q, acc_q;
  logic [IdxW-1:0]  idx_q, cnt_q;
  logic             act_q, is_mul_q, done_q;
  sel_e             dst_q;
  logic [WIDTH-1:0] sig_r_q, sig_s_q;
  status_e          status_q;

  logic [WIDTH-1:0] alu_res, mul_dbl, mul_nx, div_rem, div_quo;
  logic [WIDTH:0]   rem_sh, rem_sub;
  logic             div_ge, unit_fin, unit_start, wen;
  sel_e             wsel;
  logic [WIDTH-1:0] wdata;

  function automatic logic [WIDTH-1:0] add_m(logic [WIDTH-1:0] a, logic [WIDTH-1:0] b,
                                             logic [WIDTH-1:0] m);
    logic [WIDTH-1:0] d;
    d = m - b;
    return (a >= d) ? a - d : a + b;
  endfunction

  function automatic logic [WIDTH-1:0] sub_m(logic [WIDTH-1:0] a, logic [WIDTH-1:0] b,
                                             logic [WIDTH-1:0] m);
    return (a >= b) ? a - b : a + (m - b);
  endfunction

  function automatic logic [WIDTH-1:0] rd(sel_e s);
    logic [WIDTH-1:0] v;
    unique case (s)
      R_M:     v = m_q;
      R_QT:    v = qt_q;
      R_K:     v = k_q;
      R_MSG:   v = msg_q;
      C_ZERO:  v = '0;
      C_ONE:   v = WIDTH'(1);
      C_TWO:   v = WIDTH'(2);
      C_THREE: v = WIDTH'(3);
      C_P:     v = p_q;
      C_Q:     v = q_q;
      C_CA:    v = ca_q;
      C_BX:    v = bx_q;
      C_BY:    v = by_q;
      C_PRIV:  v = priv_q;
      default: v = rf_q[RfIdxW'(s)];
    endcase
    return v;
  endfunction

  // combinational ALU
  always_comb begin
    unique case (cmd_i.op)
      OP_ADD:  alu_res = add_m(opa_q, opb_q, m_q);
      OP_SUB:  alu_res = sub_m(opa_q, opb_q, m_q);
      OP_CSUB: alu_res = (opa_q >= opb_q) ? opa_q - opb_q : opa_q;
      default: alu_res = opa_q;
    endcase
  end

  // one multiplier bit (double, then add) or one quotient bit per cycle
  assign mul_dbl = add_m(acc_q, acc_q, m_q);
  assign mul_nx  = mb_q[WIDTH-1] ? add_m(mul_dbl, ma_q, m_q) : mul_dbl;
  assign rem_sh  = {acc_q, mb_q[WIDTH-1]};
  assign rem_sub = rem_sh - {1'b0, ma_q};
  assign div_ge  = (rem_sh >= {1'b0, ma_q});
  assign div_rem = div_ge ? rem_sub[WIDTH-1:0] : rem_sh[WIDTH-1:0];
  assign div_quo = {mb_q[WIDTH-2:0], div_ge};

  assign unit_fin   = act_q && (cnt_q == '0);
  assign unit_start = cmd_i.exec && (cmd_i.op == OP_MUL || cmd_i.op == OP_DIV);

  always_comb begin
    wen   = 1'b0;
    wsel  = cmd_i.dst;
    wdata = alu_res;
    if (unit_fin) begin
      wen   = 1'b1;
      wsel  = dst_q;
      wdata = is_mul_q ? mul_nx : div_rem;
    end else if (cmd_i.exec && (cmd_i.op == OP_MOV || cmd_i.op == OP_ADD ||
                                cmd_i.op == OP_SUB || cmd_i.op == OP_CSUB)) begin
      wen = 1'b1;
    end
  end

  assign sts_o = '{eq: (opa_q == opb_q), lt: (opa_q < opb_q), kbit: k_q[idx_q],
                   mbit: msg_q[idx_q], izero: (idx_q == '0), done: unit_fin};

  always_ff @(posedge clk_i) begin
    if (wen && wsel < NumRf) begin
      rf_q[RfIdxW'(wsel)] <= wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.fetch) begin
      opa_q <= rd(cmd_i.sa);
      opb_q <= rd(cmd_i.sb);
    end
    if (cmd_i.load) begin
      k_q   <= nonce_i;
      msg_q <= message_i;
    end
    if (wen && wsel == R_M) m_q <= wdata;
    if (unit_fin && !is_mul_q) begin
      qt_q <= div_quo;
    end else if (wen && wsel == R_QT) begin
      qt_q <= wdata;
    end
    if (unit_start) begin
      dst_q <= cmd_i.dst;
      acc_q <= '0;
      ma_q  <= (cmd_i.op == OP_MUL) ? opa_q : opb_q;
      mb_q  <= (cmd_i.op == OP_MUL) ? opb_q : opa_q;
    end else if (act_q) begin
      acc_q <= is_mul_q ? mul_nx : div_rem;
      mb_q  <= is_mul_q ? {mb_q[WIDTH-2:0], 1'b0} : div_quo;
    end
    if (cmd_i.exec && cmd_i.op == OP_FIN) begin
      status_q <= cmd_i.code;
      sig_r_q  <= (cmd_i.code == STS_OK) ? opa_q : '0;
      sig_s_q  <= (cmd_i.code == STS_OK) ? opb_q : '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_q      <= WIDTH'(FieldPrimeRst);
      ca_q     <= WIDTH'(CoeffARst);
      q_q      <= WIDTH'(GroupOrderRst);
      bx_q     <= WIDTH'(BaseXRst);
      by_q     <= WIDTH'(BaseYRst);
      priv_q   <= WIDTH'(PrivKeyRst);
      act_q    <= 1'b0;
      is_mul_q <= 1'b0;
      cnt_q    <= '0;
      idx_q    <= '0;
      done_q   <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_FIELD_PRIME:   p_q    <= cfg_data_i;
          CFG_CURVE_COEFF_A: ca_q   <= cfg_data_i;
          CFG_GROUP_ORDER:   q_q    <= cfg_data_i;
          CFG_BASE_X:        bx_q   <= cfg_data_i;
          CFG_BASE_Y:        by_q   <= cfg_data_i;
          CFG_PRIVATE_KEY:   priv_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (unit_start) begin
        act_q    <= 1'b1;
        is_mul_q <= (cmd_i.op == OP_MUL);
        cnt_q    <= IdxW'(WIDTH - 1);
      end else if (act_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == '0) act_q <= 1'b0;
      end
      if (cmd_i.exec && cmd_i.op == OP_ISET) begin
        idx_q <= IdxW'(WIDTH - 1);
      end else if (cmd_i.exec && cmd_i.op == OP_IDEC) begin
        idx_q <= idx_q - 1'b1;
      end
      done_q <= cmd_i.exec && (cmd_i.op == OP_FIN);
    end
  end

  assign done_o   = done_q;
  assign sig_r_o  = sig_r_q;
  assign sig_s_o  = sig_s_q;
  assign status_o = status_q;

`ifndef ASSERT_OFF
  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |=> !done_q)
    else $error("result strobe longer than one cycle");
  a_unit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    unit_start |-> !act_q)
    else $error("mul/div unit restarted while running");
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_q && status_q != STS_OK) |-> (sig_r_q == '0 && sig_s_q == '0))
    else $error("nonzero signature with error status");
`endif

endmodule

FILE: sv/ecdsa_sign_small_curve_unit.sv
// Run time is data-dependent: each simple microstep passes through fetch and exec, and
// each modular multiply or divide also waits for the shared bit-serial unit to finish.
// Throughput: one item at a time; start is taken again from the cycle the strobe is high.
// The result shows on done_o for one cycle and the receiver cannot stall it.
// Reset clears the sequencer and loads the curve registers with their default values.
// Top level: joins ecdsa_ctrl and ecdsa_dp; depends on ecdsa_pkg.
module ecdsa_sign_small_curve_unit import ecdsa_pkg::*; #(
  parameter int unsigned WIDTH = WidthDefault
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic [WIDTH-1:0]   message_i,
  input  logic [WIDTH-1:0]   nonce_i,
  output logic               done_o,
  output logic [WIDTH-1:0]   sig_r_o,
  output logic [WIDTH-1:0]   sig_s_o,
  output logic [StatusW-1:0] status_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [WIDTH-1:0]   cfg_data_i
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  assign cfg_ready_o = 1'b1;

  ecdsa_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .busy_o  (busy),
    .cmd_o   (cmd),
    .sts_i   (sts)
  );

  ecdsa_dp #(.WIDTH(WIDTH)) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .cfg_we_i   (cfg_valid_i & cfg_ready_o),
    .cfg_idx_i  (cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .message_i  (message_i),
    .nonce_i    (nonce_i),
    .done_o     (done_o),
    .sig_r_o    (sig_r_o),
    .sig_s_o    (sig_s_o),
    .status_o   (status_o)
  );

endmodule

FILE: tb/tb_ecdsa_sign_small_curve_unit.sv
// Testbench for ecdsa_sign_small_curve_unit: random and directed signing jobs under
// several curve settings, checked against an in-bench signature predictor.
// Depends on ecdsa_pkg and the RTL of the signer.
module tb_ecdsa_sign_small_curve_unit;
  import ecdsa_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned W        = WidthDefault;
  localparam int unsigned StallMax = 200000;
  localparam int unsigned NumPhase = 12;

  typedef logic [W-1:0] word_t;

  typedef struct {
    bit       is_cfg;
    cfg_idx_e idx;
    word_t    data;
    word_t    msg;
    word_t    nonce;
  } job_t;

  typedef struct {
    word_t   r;
    word_t   s;
    status_e sts;
  } sig_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  word_t message_i = '0;
  word_t nonce_i = '0;
  logic done_o;
  word_t sig_r_o, sig_s_o;
  logic [StatusW-1:0] status_o;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [CfgIdxW-1:0] cfg_index_i = '0;
  word_t cfg_data_i = '0;

  job_t  jobs[$];
  sig_t  sigs_due[$];
  word_t curve_cfg[6] = '{11, 1, 13, 2, 7, 1};
  int    errors = 0;
  int    gap = 0;
  int    idle_cycles = 0;

  always #5 clk_i = ~clk_i;

  ecdsa_sign_small_curve_unit dut (.*);

  // ---------------- modular arithmetic and curve predictor ----------------
  function automatic longint unsigned addm(longint unsigned a, b, m);
    return (a + b) % m;
  endfunction

  function automatic longint unsigned subm(longint unsigned a, b, m);
    return (a >= b) ? a - b : a + (m - b);
  endfunction

  function automatic longint unsigned mulm(longint unsigned a, b, m);
    return (a * b) % m;
  endfunction

  function automatic bit invm(longint unsigned a, m, output longint unsigned res);
    longint unsigned r0, r1, t0, t1, qt, tmp;
    r0 = m; r1 = a; t0 = 0; t1 = 1; res = 0;
    while (r1 != 0) begin
      qt = r0 / r1;
      tmp = r0 - qt * r1;
      r0 = r1;
      r1 = tmp;
      tmp = subm(t0, mulm(qt % m, t1, m), m);
      t0 = t1;
      t1 = tmp;
    end
    res = t0;
    return r0 == 1;
  endfunction

  function automatic bit pt_dbl(inout longint unsigned x, y, input longint unsigned a, p);
    longint unsigned iv, lam, num, x3;
    if (!invm(addm(y, y, p), p, iv)) return 0;
    num = mulm(x, x, p);
    num = addm(addm(addm(num, num, p), num, p), a, p);
    lam = mulm(num, iv, p);
    x3 = subm(mulm(lam, lam, p), addm(x, x, p), p);
    y = subm(mulm(lam, subm(x, x3, p), p), y, p);
    x = x3;
    return 1;
  endfunction

  function automatic bit pt_add(inout longint unsigned x, y,
                                input longint unsigned x2, y2, a, p);
    longint unsigned iv, lam, x3;
    if (x == x2 && y == y2) return pt_dbl(x, y, a, p);
    if (!invm(subm(x2, x, p), p, iv)) return 0;
    lam = mulm(subm(y2, y, p), iv, p);
    x3 = subm(subm(mulm(lam, lam, p), x, p), x2, p);
    y = subm(mulm(lam, subm(x, x3, p), p), y, p);
    x = x3;
    return 1;
  endfunction

  function automatic sig_t sign_msg(word_t msg, word_t k);
    sig_t o;
    longint unsigned p, q, kinv, a, ax, ay, x, y, r, h, b2, s;
    int top;
    p = curve_cfg[CFG_FIELD_PRIME];
    q = curve_cfg[CFG_GROUP_ORDER];
    o = '{r: '0, s: '0, sts: STS_OK};
    if (q < 2 || k == 0 || k >= q || !invm(k, q, kinv)) begin
      o.sts = STS_BAD_NONCE;
      return o;
    end
    if (p < 3) begin
      o.sts = STS_INFINITY;
      return o;
    end
    a = curve_cfg[CFG_CURVE_COEFF_A] % p;
    ax = curve_cfg[CFG_BASE_X] % p;
    ay = curve_cfg[CFG_BASE_Y] % p;
    x = ax;
    y = ay;
    top = W - 1;
    while (top > 0 && !k[top]) top--;
    for (int i = top - 1; i >= 0; i--) begin
      if (!pt_dbl(x, y, a, p) || (k[i] && !pt_add(x, y, ax, ay, a, p))) begin
        o.sts = STS_INFINITY;
        return o;
      end
    end
    r = x % q;
    if (r == 0) begin
      o.sts = STS_R_ZERO;
      return o;
    end
    // toy hash: 2^msg mod q, square-and-multiply
    h = 1 % q;
    b2 = 2 % q;
    for (int i = 0; i < W; i++) begin
      if (msg[i]) h = mulm(h, b2, q);
      b2 = mulm(b2, b2, q);
    end
    s = mulm(kinv, addm(h, mulm(curve_cfg[CFG_PRIVATE_KEY] % q, r, q), q), q);
    if (s == 0) begin
      o.sts = STS_S_ZERO;
      return o;
    end
    o.r = word_t'(r);
    o.s = word_t'(s);
    return o;
  endfunction

  // ---------------- stimulus helpers ----------------
  task automatic push_curve(word_t p, a, q, bx, by, m);
    word_t v[6];
    v = '{p, a, q, bx, by, m};
    for (int i = 0; i < 6; i++)
      jobs.push_back('{is_cfg: 1'b1, idx: cfg_idx_e'(i), data: v[i], msg: '0, nonce: '0});
  endtask

  task automatic push_sign(word_t msg, word_t k);
    jobs.push_back('{is_cfg: 1'b0, idx: CFG_FIELD_PRIME, data: '0, msg: msg, nonce: k});
  endtask

  task automatic push_random_signs(int n, word_t q);
    int sel;
    word_t k;
    for (int i = 0; i < n; i++) begin
      sel = $urandom_range(99);
      if (sel < 70 && q >= 2) k = word_t'($urandom_range(q - 1, 1));
      else if (sel < 85) k = word_t'($urandom);
      else begin
        case ($urandom_range(3))
          0: k = '0;
          1: k = q;
          2: k = q - 1;
          default: k = 1;
        endcase
      end
      push_sign(word_t'($urandom), k);
    end
  endtask

  function automatic int rand_gap();
    int sel;
    sel = $urandom_range(99);
    if (sel < 40) return 0;
    if (sel < 90) return $urandom_range(3);
    return $urandom_range(60, 4);
  endfunction

  // ---------------- driver ----------------
  always @(posedge clk_i) begin
    logic start_nxt, cfg_nxt;
    job_t j;
    start_nxt = start;
    cfg_nxt = cfg_valid_i;
    if (rst_ni) begin
      if (start && !busy) begin
        sigs_due.push_back(sign_msg(message_i, nonce_i));
        start_nxt = 1'b0;
        idle_cycles = 0;
      end
      if (cfg_valid_i && cfg_ready_o) begin
        curve_cfg[cfg_index_i] = cfg_data_i;
        cfg_nxt = 1'b0;
        idle_cycles = 0;
      end
      if (gap > 0) begin
        gap--;
      end else if (!start_nxt && !cfg_nxt && jobs.size() > 0) begin
        j = jobs[0];
        if (!j.is_cfg) begin
          void'(jobs.pop_front());
          start_nxt = 1'b1;
          message_i <= j.msg;
          nonce_i <= j.nonce;
          gap = rand_gap();
        end else if (sigs_due.size() == 0 && !busy && !start) begin
          // register writes only while the signer sits idle
          void'(jobs.pop_front());
          cfg_nxt = 1'b1;
          cfg_index_i <= j.idx;
          cfg_data_i <= j.data;
          gap = rand_gap();
        end
      end
    end
    start <= start_nxt;
    cfg_valid_i <= cfg_nxt;
  end

  // ---------------- monitor and watchdog ----------------
  task automatic report(string what, logic [W-1:0] got, logic [W-1:0] want);
    errors++;
    $display("%0t: %s got %0d want %0d", $realtime, what, got, want);
  endtask

  always @(posedge clk_i) begin
    sig_t e;
    if (rst_ni && done_o) begin
      idle_cycles = 0;
      if (sigs_due.size() == 0) begin
        report("result with nothing due, status", W'(status_o), '0);
      end else begin
        e = sigs_due.pop_front();
        if (status_o !== e.sts) report("status", W'(status_o), W'(e.sts));
        if (sig_r_o !== e.r) report("sig_r", sig_r_o, e.r);
        if (sig_s_o !== e.s) report("sig_s", sig_s_o, e.s);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      idle_cycles++;
      if (idle_cycles > StallMax) begin
        $display("ecdsa_sign_small_curve_unit: mismatch");
        $finish;
      end
    end
  end

  // ---------------- sequence ----------------
  initial begin
    word_t primes[10];
    word_t p, q;

    primes = '{3, 5, 7, 11, 13, 17, 97, 251, 257, 65521};
    // reset curve: nonce range edges, hash exponent edges, nonce of one
    push_sign(16'd0, 16'd0);
    push_sign(16'hffff, 16'd13);
    push_sign(16'd5, 16'hffff);
    push_sign(16'd0, 16'd1);
    push_sign(16'hffff, 16'd12);
    for (int i = 2; i < 12; i++) push_sign(word_t'($urandom), word_t'(i));
    // largest sizes, composite q (non-invertible nonce) and composite p
    push_curve(16'd65521, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff);
    push_sign(16'hffff, 16'hfffe);
    push_sign(16'h1234, 16'd3);
    push_sign(16'h0, 16'd5);
    push_curve(16'hffff, 16'd0, 16'd65521, 16'd0, 16'd0, 16'd0);
    push_sign(16'd7, 16'd2);
    push_sign(16'd7, 16'd1);
    // field modulus below three, smallest group order
    push_curve(16'd2, 16'd1, 16'd2, 16'd1, 16'd1, 16'd1);
    push_sign(16'd1, 16'd1);
    push_sign(16'd1, 16'd2);
    push_curve(16'd3, 16'd0, 16'd7, 16'd1, 16'd0, 16'd3);
    push_sign(16'd9, 16'd2);
    push_sign(16'd9, 16'd4);

    for (int ph = 0; ph < NumPhase; ph++) begin
      p = (ph % 4 == 3) ? word_t'($urandom_range(65535, 3)) : primes[$urandom_range(9)];
      q = (ph % 3 == 2) ? word_t'($urandom_range(65535, 2)) : primes[$urandom_range(9)];
      if (ph == NumPhase - 1) q = 16'hffff;
      push_curve(p, word_t'($urandom), q, word_t'($urandom), word_t'($urandom),
                 word_t'($urandom));
      push_random_signs(23, q);
    end
    push_curve(16'd11, 16'd1, 16'd13, 16'd2, 16'd7, 16'd1);
    push_random_signs(10, 16'd13);

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    while (jobs.size() > 0 || start || cfg_valid_i || sigs_due.size() > 0)
      @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    if (errors == 0 && sigs_due.size() == 0) begin
      $display("ecdsa_sign_small_curve_unit: match");
    end else begin
      $display("ecdsa_sign_small_curve_unit: mismatch");
    end
    $finish;
  end

endmodule
